[sv/hdg_pkg.sv]
`default_nettype none
package hdg_pkg;

    localparam logic [32:0] PI_HALF_Q30 = 33'd1686629713;
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;

    // quadrant boundaries: r >= j*pi/2 - pi/4
    localparam logic [32:0] QUAD_T1 = 33'd843314857;
    localparam logic [32:0] QUAD_T2 = 33'd2529944570;
    localparam logic [32:0] QUAD_T3 = 33'd4216574283;
    localparam logic [32:0] QUAD_T4 = 33'd5903203996;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam int unsigned SIN_N = 4;
    localparam int unsigned COS_N = 5;
    localparam int unsigned SIN_DIV [SIN_N] = '{72, 42, 20, 6};
    localparam int unsigned COS_DIV [COS_N] = '{90, 56, 30, 12, 2};

    localparam int CFG_W = 32;
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] CFG_REF_LON = 2'd0;
    localparam logic [IDX_W-1:0] CFG_REF_LAT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_THRESH  = 2'd2;

    localparam logic [29:0] THRESH_RESET = 30'd13019;

    typedef struct packed {
        logic       last;
        logic       rej;
    } t_side;

    typedef struct packed {
        logic [29:0] distance;
        logic        rej;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]  k;
        logic        neg;
        logic [29:0] u;
    } t_quad;

    // q30 product, rounded half up
    function automatic logic [33:0] umul30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + 64'd536870912;
        return p[63:30];
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage
`default_nettype wire

[sv/hdg_mod_cell.sv]
`default_nettype none
module hdg_mod_cell #(
    parameter int W  = 36,
    parameter int SH = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_v,
    output logic      [W-1:0] o_v
);
    import hdg_pkg::*;

    localparam logic [W-1:0] C = W'(TWO_PI_Q30) << SH;

    logic [W-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= (i_v >= C) ? (i_v - C) : i_v;
        end
    end

    assign o_v = r_v;

endmodule
`default_nettype wire

[sv/hdg_horner_cell.sv]
`default_nettype none
module hdg_horner_cell #(
    parameter int unsigned D = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [29:0] i_u2,
    input  wire logic [30:0] i_t,
    output logic      [29:0] o_u2,
    output logic      [30:0] o_t
);
    import hdg_pkg::*;

    localparam logic [63:0] M = (64'd1 << 32) / D;

    logic [29:0] r_p1, r_u2_1;
    logic [29:0] r_m2, r_p2, r_u2_2;
    logic [30:0] r_t3;
    logic [29:0] r_u2_3;

    logic [33:0] p_full;
    logic [63:0] m_full;
    logic [36:0] rem;
    logic [29:0] q;

    always_comb begin
        p_full = umul30({2'b00, i_u2}, {1'b0, i_t});
        m_full = 64'(r_p1) * M;
        rem    = 37'(r_p2) - 37'(r_m2) * 37'(D);
        q      = r_m2 + ((rem >= 37'(D)) ? 30'd1 : 30'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= p_full[29:0];
            r_u2_1 <= i_u2;
            r_m2   <= m_full[61:32];
            r_p2   <= r_p1;
            r_u2_2 <= r_u2_1;
            r_t3   <= Q30_ONE - 31'(q);
            r_u2_3 <= r_u2_2;
        end
    end

    assign o_u2 = r_u2_3;
    assign o_t  = r_t3;

endmodule
`default_nettype wire

[sv/hdg_sincos.sv]
`default_nettype none
module hdg_sincos #(
    parameter int W = 35
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [W-1:0] i_x,
    output logic signed      [31:0]  o_sin,
    output logic signed      [31:0]  o_cos
);
    import hdg_pkg::*;

    localparam int K  = W - 32;
    localparam int VW = W + 1;
    localparam logic [VW-1:0] OFF = VW'(TWO_PI_Q30) << K;

    logic [VW-1:0] r_v0;
    logic [VW-1:0] w_v [K+2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v0 <= {i_x[W-1], i_x} + OFF;
        end
    end

    assign w_v[0] = r_v0;

    for (genvar i = 0; i <= K; i++) begin : g_red
        hdg_mod_cell #(.W(VW), .SH(K - i)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_v   (w_v[i]),
            .o_v   (w_v[i+1])
        );
    end

    logic [32:0]        r33;
    logic [2:0]         kk;
    logic signed [33:0] rem;
    t_quad              quad;

    always_comb begin
        r33 = w_v[K+1][32:0];
        kk  = 3'(r33 >= QUAD_T1) + 3'(r33 >= QUAD_T2) + 3'(r33 >= QUAD_T3)
            + 3'(r33 >= QUAD_T4);
        case (kk)
            3'd1:    rem = $signed({1'b0, r33}) - $signed({1'b0, PI_HALF_Q30});
            3'd2:    rem = $signed({1'b0, r33}) - $signed({1'b0, PI_Q30});
            3'd3:    rem = $signed({1'b0, r33}) - $signed({1'b0, PI_Q30})
                         - $signed({1'b0, PI_HALF_Q30});
            3'd4:    rem = $signed({1'b0, r33}) - $signed({1'b0, TWO_PI_Q30});
            default: rem = $signed({1'b0, r33});
        endcase
        quad.k   = kk[1:0];
        quad.neg = rem[33];
        quad.u   = rem[33] ? 30'(-rem) : rem[29:0];
    end

    t_quad       r_q;
    logic [29:0] r_u2;
    t_quad       r_qd [16];
    logic [33:0] u2_full;

    assign u2_full = umul30({2'b00, r_q.u}, {2'b00, r_q.u});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q     <= quad;
            r_u2    <= u2_full[29:0];
            r_qd[0] <= r_q;
            for (int i = 1; i < 16; i++) begin
                r_qd[i] <= r_qd[i-1];
            end
        end
    end

    logic [30:0] w_ts  [SIN_N+1];
    logic [29:0] w_tsu [SIN_N];
    logic [30:0] w_tc  [COS_N+1];
    logic [29:0] w_tcu [COS_N];

    assign w_ts[0]  = Q30_ONE;
    assign w_tsu[0] = r_u2;
    assign w_tc[0]  = Q30_ONE;
    assign w_tcu[0] = r_u2;

    for (genvar i = 0; i < SIN_N; i++) begin : g_sin
        if (i < SIN_N - 1) begin : g_mid
            hdg_horner_cell #(.D(SIN_DIV[i])) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_u2  (w_tsu[i]), .i_t (w_ts[i]),
                .o_u2  (w_tsu[i+1]), .o_t (w_ts[i+1])
            );
        end else begin : g_end
            hdg_horner_cell #(.D(SIN_DIV[i])) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_u2  (w_tsu[i]), .i_t (w_ts[i]),
                .o_u2  (), .o_t (w_ts[i+1])
            );
        end
    end

    for (genvar i = 0; i < COS_N; i++) begin : g_cos
        if (i < COS_N - 1) begin : g_mid
            hdg_horner_cell #(.D(COS_DIV[i])) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_u2  (w_tcu[i]), .i_t (w_tc[i]),
                .o_u2  (w_tcu[i+1]), .o_t (w_tc[i+1])
            );
        end else begin : g_end
            hdg_horner_cell #(.D(COS_DIV[i])) u_cell (
                .i_clk (i_clk), .i_en (i_en),
                .i_u2  (w_tcu[i]), .i_t (w_tc[i]),
                .o_u2  (), .o_t (w_tc[i+1])
            );
        end
    end

    logic [33:0] sr_full;
    logic [30:0] r_sr, r_sr1, r_sr2;

    assign sr_full = umul30({2'b00, r_qd[12].u}, {1'b0, w_ts[SIN_N]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr  <= sr_full[30:0];
            r_sr1 <= r_sr;
            r_sr2 <= r_sr1;
        end
    end

    logic signed [31:0] sr_s, cr_s, n_sin, n_cos;
    logic signed [31:0] r_sin, r_cos;

    always_comb begin
        sr_s = r_qd[15].neg ? -$signed({1'b0, r_sr2}) : $signed({1'b0, r_sr2});
        cr_s = $signed({1'b0, w_tc[COS_N]});
        case (r_qd[15].k)
            2'd0:    begin n_sin = sr_s;  n_cos = cr_s;  end
            2'd1:    begin n_sin = cr_s;  n_cos = -sr_s; end
            2'd2:    begin n_sin = -sr_s; n_cos = -cr_s; end
            default: begin n_sin = -cr_s; n_cos = sr_s;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

[sv/hdg_sqrt_cell.sv]
`default_nettype none
module hdg_sqrt_cell #(
    parameter int SH = 62
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_v,
    input  wire logic [63:0] i_root,
    output logic      [63:0] o_v,
    output logic      [63:0] o_root
);
    localparam logic [63:0] BIT = 64'd1 << SH;

    logic [63:0] trial;
    logic [63:0] r_v, r_root;

    assign trial = i_root + BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_v >= trial) begin
                r_v    <= i_v - trial;
                r_root <= (i_root >> 1) + BIT;
            end else begin
                r_v    <= i_v;
                r_root <= i_root >> 1;
            end
        end
    end

    assign o_v    = r_v;
    assign o_root = r_root;

endmodule
`default_nettype wire

[sv/haversine_distance_gate.sv]
`default_nettype none
// Small-angle haversine distance with a longitude gate. One point is accepted per
// cycle while o_in_ready is high, and results leave in order through the sin/cos
// cell chains (modulo 2pi reduction, Horner steps; AW = 33 + max(30 - FRAC_BITS, 0)
// sets their width) and the 32-cell square root chain; an output register
// with a skid stage keeps input flowing while a result waits. After reset and after
// every ref_lat write, o_in_ready stays low while cos(ref_lat) runs through its own
// sin/cos chain.
module haversine_distance_gate #(
    parameter int FRAC_BITS = 28
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [hdg_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [hdg_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [31:0]         i_point_lon,
    input  wire logic signed [29:0]         i_point_lat,
    input  wire logic                       i_last_point,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [29:0]                     o_distance,
    output logic                            o_rejected,
    output logic                            o_last_out
);
    import hdg_pkg::*;

    localparam int UP_SH  = (FRAC_BITS <= 30) ? (30 - FRAC_BITS) : 0;
    localparam int DN_SH  = (FRAC_BITS > 30) ? (FRAC_BITS - 30) : 0;
    localparam int AW     = 33 + UP_SH;
    localparam int SC_LAT = AW - 12;
    localparam int SQ_N   = 32;
    localparam int P      = SC_LAT + 4 + SQ_N;
    localparam int BW     = $clog2(SC_LAT + 3);
    localparam int DW     = 34 + DN_SH;
    localparam logic signed [AW-1:0] DN_BIAS = AW'((64'd1 << DN_SH) - 64'd1);
    localparam logic [DW-1:0] RND = DW'((64'd1 << UP_SH) >> 1);

    function automatic logic signed [AW-1:0] to_q30(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] b;
        b = v + (v[AW-1] ? DN_BIAS : '0);
        return (b >>> DN_SH) <<< UP_SH;
    endfunction

    function automatic logic signed [AW-1:0] half(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] b;
        b = v + $signed(AW'(v[AW-1]));
        return b >>> 1;
    endfunction

    // configuration
    logic [31:0] r_ref_lon;
    logic [29:0] r_ref_lat;
    logic [29:0] r_thresh;
    logic [BW-1:0] r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_lon <= '0;
            r_ref_lat <= '0;
            r_thresh  <= THRESH_RESET;
            r_busy    <= BW'(SC_LAT + 2);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_REF_LON: r_ref_lon <= i_cfg_data;
                    CFG_REF_LAT: r_ref_lat <= i_cfg_data[29:0];
                    CFG_THRESH:  r_thresh  <= i_cfg_data[29:0];
                    default:     ;
                endcase
            end
            if (i_cfg_we && i_cfg_index == CFG_REF_LAT) begin
                r_busy <= BW'(SC_LAT + 2);
            end else if (r_busy != '0) begin
                r_busy <= r_busy - 1'b1;
            end
        end
    end

    // cos(ref_lat)
    logic signed [AW-1:0] ref_lat_e, ref_lat_q;
    logic signed [31:0]   w_c_ref, r_cos_ref;

    always_comb begin
        ref_lat_e = AW'($signed(r_ref_lat));
        ref_lat_q = to_q30(ref_lat_e);
    end

    hdg_sincos #(.W(AW)) u_cos_ref (
        .i_clk (i_clk), .i_en (1'b1), .i_x (ref_lat_q),
        .o_sin (), .o_cos (w_c_ref)
    );

    always_ff @(posedge i_clk) begin
        r_cos_ref <= w_c_ref;
    end

    // pipeline control
    logic r_skid_v, r_out_v;
    logic w_en, in_fire;
    logic r_vld [P+1];

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en && (r_busy == '0);
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= P; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= in_fire;
            for (int i = 1; i <= P; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // input stage
    logic signed [32:0]   dlon_raw;
    logic signed [30:0]   dlat_raw;
    logic signed [AW-1:0] dlon_e, dlat_e, plat_e, dlon_q, dlat_q, plat_q;
    logic signed [AW-1:0] r_x_lon, r_x_lat, r_x_plat;
    logic [AW-1:0]        r_adlon;

    always_comb begin
        dlon_raw = $signed({i_point_lon[31], i_point_lon}) - $signed({r_ref_lon[31], r_ref_lon});
        dlat_raw = $signed({i_point_lat[29], i_point_lat}) - $signed({r_ref_lat[29], r_ref_lat});
        dlon_e   = AW'(dlon_raw);
        dlat_e   = AW'(dlat_raw);
        plat_e   = AW'(i_point_lat);
        dlon_q   = to_q30(dlon_e);
        dlat_q   = to_q30(dlat_e);
        plat_q   = to_q30(plat_e);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_lon  <= half(dlon_q);
            r_x_lat  <= half(dlat_q);
            r_x_plat <= plat_q;
            r_adlon  <= dlon_q[AW-1] ? AW'(-dlon_q) : AW'(dlon_q);
        end
    end

    // longitude gate
    logic [62:0] r_g_prod;
    logic        r_g_ok, gate;
    logic [63:0] th30;

    always_comb begin
        th30 = (64'(r_thresh) << UP_SH) >> DN_SH;
        gate = r_g_ok && (64'(r_g_prod) > (th30 << 30));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_prod <= 63'(r_adlon[31:0]) * 63'(r_cos_ref[30:0]);
            r_g_ok   <= (r_cos_ref > 0) && (r_adlon < AW'(PI_Q30)) && (th30[63:32] == '0);
        end
    end

    t_side r_side [P+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= '{last: i_last_point, rej: 1'b0};
            r_side[1] <= r_side[0];
            r_side[2] <= '{last: r_side[1].last, rej: gate};
            for (int i = 3; i <= P; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // sines and cosine
    logic signed [31:0] w_s_lat, w_s_lon, w_c_p;

    hdg_sincos #(.W(AW)) u_sc_lat (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_x_lat), .o_sin (w_s_lat), .o_cos ()
    );
    hdg_sincos #(.W(AW)) u_sc_lon (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_x_lon), .o_sin (w_s_lon), .o_cos ()
    );
    hdg_sincos #(.W(AW)) u_sc_plat (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_x_plat), .o_sin (), .o_cos (w_c_p)
    );

    // haversine sum
    logic [33:0] sl2_f, so2_f, cp_f, t_f;
    logic [31:0] r_sl2, r_so2, r_cp_mag, r_sl2_d, r_t_mag;
    logic        r_cp_neg, r_t_neg;
    logic signed [33:0] a_s;
    logic [31:0] r_a;

    always_comb begin
        sl2_f = umul30(abs32(w_s_lat), abs32(w_s_lat));
        so2_f = umul30(abs32(w_s_lon), abs32(w_s_lon));
        cp_f  = umul30(abs32(r_cos_ref), abs32(w_c_p));
        t_f   = umul30(r_cp_mag, r_so2);
        a_s   = r_t_neg ? ($signed({2'b00, r_sl2_d}) - $signed({2'b00, r_t_mag}))
                        : ($signed({2'b00, r_sl2_d}) + $signed({2'b00, r_t_mag}));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sl2    <= sl2_f[31:0];
            r_so2    <= so2_f[31:0];
            r_cp_mag <= cp_f[31:0];
            r_cp_neg <= r_cos_ref[31] ^ w_c_p[31];
            r_t_mag  <= t_f[31:0];
            r_t_neg  <= r_cp_neg;
            r_sl2_d  <= r_sl2;
            r_a      <= a_s[33] ? 32'd0 : a_s[31:0];
        end
    end

    // square root
    logic [63:0] w_sv [SQ_N+1];
    logic [63:0] w_sr [SQ_N+1];

    assign w_sv[0] = {2'b00, r_a, 30'd0};
    assign w_sr[0] = '0;

    for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
        if (i < SQ_N - 1) begin : g_mid
            hdg_sqrt_cell #(.SH(62 - 2 * i)) u_cell (
                .i_clk (i_clk), .i_en (w_en),
                .i_v (w_sv[i]), .i_root (w_sr[i]),
                .o_v (w_sv[i+1]), .o_root (w_sr[i+1])
            );
        end else begin : g_end
            hdg_sqrt_cell #(.SH(62 - 2 * i)) u_cell (
                .i_clk (i_clk), .i_en (w_en),
                .i_v (w_sv[i]), .i_root (w_sr[i]),
                .o_v (), .o_root (w_sr[i+1])
            );
        end
    end

    logic [DW-1:0] d_w;
    logic [29:0]   r_dist;

    assign d_w = ((DW'({w_sr[SQ_N][31:0], 1'b0}) + RND) >> UP_SH) << DN_SH;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_side[P-1].rej) begin
                r_dist <= '0;
            end else if (d_w > DW'(30'h3fff_ffff)) begin
                r_dist <= 30'h3fff_ffff;
            end else begin
                r_dist <= d_w[29:0];
            end
        end
    end

    // output register and skid
    t_result pipe_res, r_out, r_skid;
    logic    push;

    assign pipe_res = '{distance: r_dist, rej: r_side[P].rej, last: r_side[P].last};
    assign push     = w_en && r_vld[P];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_out_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            r_out <= r_skid_v ? r_skid : pipe_res;
        end else if (push) begin
            r_skid <= pipe_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_distance  = r_out.distance;
    assign o_rejected  = r_out.rej;
    assign o_last_out  = r_out.last;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready))
        else $error("skid filled without a stalled output");

    a_busy_after_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == CFG_REF_LAT) |=> !o_in_ready)
        else $error("transfer accepted while cos of reference latitude settles");

    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> (o_distance == '0))
        else $error("rejected result with nonzero distance");
`endif

endmodule
`default_nettype wire
